### sv/rgbrle_pkg.sv
// Shared types and constants for the RGB run-length packet encoder.
// No dependencies; imported by the front end, queue, back end and top level.
`default_nettype none

package rgbrle_pkg;

  localparam int BYTE_W      = 8;
  localparam int SLOT_N      = 8;   // most bytes one pixel can cause
  localparam int SLOT_IDX_W  = 3;
  localparam int COUNT_W     = 4;   // holds 0..SLOT_N
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // header of a run of two or more pixels is this base plus count minus one
  localparam logic [BYTE_W-1:0] RUN_HDR_BASE   = 8'd128;
  localparam logic [BYTE_W-1:0] SINGLE_HDR     = 8'd0;

  // bytes of one pixel's packets, slot 0 goes out first
  typedef struct packed {
    logic [SLOT_N-1:0][BYTE_W-1:0] byte_list;
    logic [COUNT_W-1:0]            byte_count;
  } cmd_t;

endpackage

`default_nettype wire

### sv/rgbrle_front.sv
// Front end: takes pixels, keeps the open run and the mode register, and
// turns each pixel into a byte list for the queue. Depends on rgbrle_pkg.
`default_nettype none

module rgbrle_front import rgbrle_pkg::*; #(
  parameter int MAX_RUN = 128
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_data,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  input  wire logic       last_pixel,
  input  wire logic       pixel_valid,
  output logic            pixel_stall,
  input  wire logic       queue_full,
  output logic            push,
  output cmd_t            push_cmd
);

  localparam int RUN_W = $clog2(MAX_RUN + 1);

  logic             rle_enable;
  logic [23:0]      run_colour;
  logic [RUN_W-1:0] run_length;
  logic [23:0]      run_colour_next;
  logic [RUN_W-1:0] run_length_next;

  logic [23:0]            pix;
  logic                   accept;
  logic                   extend;
  logic                   has_a;
  logic                   has_b;
  logic                   b_has_hdr;
  logic [RUN_W-1:0]       len_new;
  logic [BYTE_W-1:0]      hdr_a;
  logic [BYTE_W-1:0]      hdr_b;
  logic [3:0][BYTE_W-1:0] a_bytes;
  logic [3:0][BYTE_W-1:0] b_bytes;
  logic [COUNT_W-1:0]     b_len;

  assign pix         = {red, green, blue};
  assign pixel_stall = queue_full;
  assign accept      = pixel_valid && !queue_full;

  assign extend  = (run_length != '0) && (pix == run_colour) &&
                   (run_length < RUN_W'(MAX_RUN));
  assign len_new = extend ? run_length + RUN_W'(1) : RUN_W'(1);

  assign hdr_a = (run_length > RUN_W'(1)) ?
                 RUN_HDR_BASE + BYTE_W'(run_length) - 8'd1 : SINGLE_HDR;
  assign hdr_b = (len_new > RUN_W'(1)) ?
                 RUN_HDR_BASE + BYTE_W'(len_new) - 8'd1 : SINGLE_HDR;

  // element 0 is the rightmost in each concatenation and goes out first
  always_comb begin
    run_colour_next = run_colour;
    run_length_next = run_length;
    has_a     = 1'b0;
    has_b     = 1'b0;
    b_has_hdr = 1'b0;
    a_bytes   = {run_colour[7:0], run_colour[15:8], run_colour[23:16], hdr_a};
    b_bytes   = {SINGLE_HDR, pix[7:0], pix[15:8], pix[23:16]};
    if (!rle_enable) begin
      // flush any open run, then the raw pixel
      has_a = (run_length != '0);
      has_b = 1'b1;
      run_length_next = '0;
    end else begin
      has_a = !extend && (run_length != '0);
      if (!extend) begin
        run_colour_next = pix;
      end
      run_length_next = len_new;
      if (last_pixel) begin
        has_b     = 1'b1;
        b_has_hdr = 1'b1;
        b_bytes   = {run_colour_next[7:0], run_colour_next[15:8],
                     run_colour_next[23:16], hdr_b};
        run_length_next = '0;
      end
    end
  end

  assign b_len = has_b ? (b_has_hdr ? 4'd4 : 4'd3) : 4'd0;

  always_comb begin
    if (has_a) begin
      push_cmd.byte_list  = {b_bytes, a_bytes};
      push_cmd.byte_count = 4'd4 + b_len;
    end else begin
      push_cmd.byte_list  = {32'd0, b_bytes};
      push_cmd.byte_count = b_len;
    end
  end

  assign push = accept && (has_a || has_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      rle_enable <= 1'b1;
      run_colour <= '0;
      run_length <= '0;
    end else begin
      if (cfg_write) begin
        rle_enable <= cfg_data;
      end
      if (accept) begin
        run_colour <= run_colour_next;
        run_length <= run_length_next;
      end
    end
  end

endmodule

`default_nettype wire

### sv/rgbrle_queue.sv
// Short first-in first-out queue of byte lists between front and back.
// Depends on rgbrle_pkg.
`default_nettype none

module rgbrle_queue import rgbrle_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output cmd_t      head
);

  cmd_t              entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full    = (fill == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign head    = entry[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### sv/rgbrle_back.sv
// Back end: walks the head byte list one byte per cycle, while byte_stall is low,
// into the output register and pops the queue as it loads the final byte. Depends on rgbrle_pkg.
`default_nettype none

module rgbrle_back import rgbrle_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       empty,
  input  cmd_t            head,
  output logic            pop,
  output logic [7:0]      out_byte,
  output logic            last_of_item,
  output logic            byte_valid,
  input  wire logic       byte_stall
);

  logic [SLOT_IDX_W-1:0] byte_idx;
  logic                  load;
  logic                  final_byte;

  // output register is free when empty or being taken this cycle
  assign load       = !empty && (!byte_valid || !byte_stall);
  assign final_byte = ({1'b0, byte_idx} == head.byte_count - 4'd1);
  assign pop        = load && final_byte;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= head.byte_list[byte_idx];
      last_of_item <= final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      byte_idx   <= '0;
    end else begin
      if (load) begin
        byte_valid <= 1'b1;
        byte_idx   <= final_byte ? '0 : byte_idx + SLOT_IDX_W'(1);
      end else if (!byte_stall) begin
        byte_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### sv/rgb_run_length_packet_encoder_unit.sv
// Top level of the RGB run-length packet encoder: front end, queue, back end.
// Depends on rgbrle_pkg, rgbrle_front, rgbrle_queue, rgbrle_back.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------
//   pixel    | pixel_valid / pixel_stall | red, green, blue, last_pixel
//   byte     | byte_valid / byte_stall   | out_byte, last_of_item
//   config   | cfg_write                 | cfg_data (rle_enable, resets to 1)
//
// A pixel is taken whenever the 4-entry queue has room; it
// causes 0, 3, 4, 7 or 8 output words, sent one word per cycle from the
// output register while byte_stall is low. The pixel's byte list is
// written into the queue and its first word then loaded into the output
// register. Reset clears run state, queue and output valid.
// Stalls on the byte side back up through the queue to pixel_stall.
`default_nettype none

module rgb_run_length_packet_encoder_unit import rgbrle_pkg::*; #(
  parameter int MAX_RUN = 128
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_data,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  input  wire logic       last_pixel,
  input  wire logic       pixel_valid,
  output logic            pixel_stall,
  output logic [7:0]      out_byte,
  output logic            last_of_item,
  output logic            byte_valid,
  input  wire logic       byte_stall
);

  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t push_cmd;
  cmd_t head;

  rgbrle_front #(.MAX_RUN(MAX_RUN)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .last_pixel  (last_pixel),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .queue_full  (full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  rgbrle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  rgbrle_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .head         (head),
    .pop          (pop),
    .out_byte     (out_byte),
    .last_of_item (last_of_item),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall)
  );

endmodule

`default_nettype wire

### sv/rgbrle_checker.sv
// Port-level checks for the encoder top level, attached by bind.
// Depends only on the ports of rgb_run_length_packet_encoder_unit.
`default_nettype none

module rgbrle_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       pixel_stall,
  input wire logic [7:0] out_byte,
  input wire logic       last_of_item,
  input wire logic       byte_valid,
  input wire logic       byte_stall
);

  // output register empties on reset
  a_rst_no_word: assert property (@(posedge clk) rst |=> !byte_valid)
    else $error("word shown right after reset");

  // queue is empty after reset, so pixels are taken
  a_rst_ready: assert property (@(posedge clk) rst |=> !pixel_stall)
    else $error("pixel side stalled right after reset");

  // a packet is sent without gaps until its final word
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall && !last_of_item |=> byte_valid)
    else $error("gap inside a pixel's words");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=>
      byte_valid && $stable(out_byte) && $stable(last_of_item))
    else $error("stalled word changed");

endmodule

bind rgb_run_length_packet_encoder_unit rgbrle_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_stall  (pixel_stall),
  .out_byte     (out_byte),
  .last_of_item (last_of_item),
  .byte_valid   (byte_valid),
  .byte_stall   (byte_stall)
);

`default_nettype wire

### bench/rgbrle_byte_checker.sv
// Scoreboard for the RGB run-length packet encoder: tracks rle_enable, predicts
// the encoded word stream from accepted pixels and checks the byte channel.
// Depends on rgbrle_pkg.
`timescale 1ns / 1ps

module rgbrle_byte_checker import rgbrle_pkg::*; #(
  parameter int MAX_RUN = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic       last_pixel,
  input  logic       pixel_valid,
  input  logic       pixel_stall,
  input  logic [7:0] out_byte,
  input  logic       last_of_item,
  input  logic       byte_valid,
  input  logic       byte_stall,
  output int         mismatch_count,
  output int         bytes_pending
);

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              tail;
  } coded_word_t;

  coded_word_t expected_words[$];
  logic [23:0] open_colour;
  int unsigned open_length;
  logic        rle_on;

  function automatic void push_colour(input logic [23:0] colour);
    expected_words.push_back('{colour[23:16], 1'b0});
    expected_words.push_back('{colour[15:8], 1'b0});
    expected_words.push_back('{colour[7:0], 1'b0});
  endfunction

  // emit the open run as one packet and close it
  function automatic void close_run();
    logic [BYTE_W-1:0] header;
    if (open_length == 0) return;
    header = SINGLE_HDR;
    if (open_length > 1) header = RUN_HDR_BASE + open_length[BYTE_W-1:0] - 8'd1;
    expected_words.push_back('{header, 1'b0});
    push_colour(open_colour);
    open_length = 0;
  endfunction

  function automatic void encode_pixel(input logic [23:0] colour, input logic flush_px);
    int          words_before;
    coded_word_t tail_word;
    words_before = expected_words.size();
    if (!rle_on) begin
      close_run();
      push_colour(colour);
    end else begin
      if (open_length != 0 && colour == open_colour && open_length < MAX_RUN) begin
        open_length++;
      end else begin
        close_run();
        open_colour = colour;
        open_length = 1;
      end
      if (flush_px) close_run();
    end
    if (expected_words.size() > words_before) begin
      tail_word = expected_words.pop_back();
      tail_word.tail = 1'b1;
      expected_words.push_back(tail_word);
    end
  endfunction

  always @(posedge clk) begin : compare
    coded_word_t want;
    if (rst) begin
      open_colour = '0;
      open_length = 0;
      rle_on = 1'b1;
      expected_words.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_write) rle_on = cfg_data;
      if (pixel_valid && !pixel_stall) encode_pixel({red, green, blue}, last_pixel);
      if (byte_valid && !byte_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: out_byte %0h last_of_item %0b", out_byte, last_of_item);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_byte !== want.value) begin
            $error("out_byte: expected %0h, got %0h", want.value, out_byte);
            mismatch_count++;
          end
          if (last_of_item !== want.tail) begin
            $error("last_of_item: expected %0b, got %0b", want.tail, last_of_item);
            mismatch_count++;
          end
        end
      end
    end
    bytes_pending = expected_words.size();
  end

endmodule

### bench/tb_rgb_run_length_packet_encoder_unit.sv
// Testbench top for the RGB run-length packet encoder: clock, reset, pixel and
// config stimulus, random byte-side stalls. Depends on the encoder RTL and
// rgbrle_byte_checker.
`timescale 1ns / 1ps

module tb_rgb_run_length_packet_encoder_unit;

  localparam int   MAX_RUN     = 128;
  localparam int   TOTAL_ITEMS = 250;
  localparam int   SETTLE      = 8;
  localparam int   HOLD_CYCLES = 300;
  localparam int   CYCLE_LIMIT = 500000;
  localparam logic MODE_RAW    = 1'b0;
  localparam logic MODE_RLE    = 1'b1;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic       cfg_data;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;
  logic       pixel_valid;
  logic       pixel_stall;
  logic [7:0] out_byte;
  logic       last_of_item;
  logic       byte_valid;
  logic       byte_stall;
  int         mismatch_count;
  int         bytes_pending;

  int unsigned cycle_count;
  int          items_sent;
  bit          hold_request;
  logic [23:0] prev_colour;

  rgb_run_length_packet_encoder_unit #(.MAX_RUN(MAX_RUN)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .last_pixel   (last_pixel),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .out_byte     (out_byte),
    .last_of_item (last_of_item),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall)
  );

  rgbrle_byte_checker #(.MAX_RUN(MAX_RUN)) scoreboard (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .last_pixel     (last_pixel),
    .pixel_valid    (pixel_valid),
    .pixel_stall    (pixel_stall),
    .out_byte       (out_byte),
    .last_of_item   (last_of_item),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .mismatch_count (mismatch_count),
    .bytes_pending  (bytes_pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [23:0] pick_colour(input logic [23:0] prior);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return prior;  // same as the last run, so runs merge
    if (r < 25) return $urandom_range(0, 1) ? 24'hffffff : 24'h000000;
    return 24'($urandom());
  endfunction

  function automatic int run_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // returns at the rising edge where the pixel was taken; valid stays high
  task automatic send_pixel(input logic [23:0] colour, input logic flush_px);
    int gap;
    gap = ((items_sent / 32) % 4 == 1) ? 0 : idle_gap();
    @(negedge clk);
    while (gap > 0) begin
      pixel_valid <= 1'b0;
      gap--;
      @(negedge clk);
    end
    {red, green, blue} <= colour;
    last_pixel  <= flush_px;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    items_sent++;
    prev_colour = colour;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (bytes_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_mode(input logic mode);
    wait_idle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= mode;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // a few runs; cut leaves the last run open, plus the odd stray last_pixel
  task automatic send_image(input bit cut, input int first_span);
    int          runs;
    int          span;
    logic [23:0] colour;
    logic        flush_px;
    runs = $urandom_range(1, 6);
    colour = prev_colour;
    for (int k = 0; k < runs; k++) begin
      colour = pick_colour(colour);
      span = (k == 0 && first_span > 0) ? first_span : run_span();
      for (int j = 0; j < span; j++) begin
        flush_px = (k == runs - 1 && j == span - 1 && !cut) || ($urandom_range(0, 99) < 3);
        send_pixel(colour, flush_px);
      end
    end
  endtask

  // byte side: random stalls, quiet stretches, one long hold-off
  initial begin : byte_sink
    int  stall_left;
    bit  hold_done;
    stall_left = 0;
    hold_done = 0;
    byte_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1;
        stall_left = HOLD_CYCLES - 1;
        byte_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        byte_stall <= 1'b1;
      end else begin
        if ((cycle_count / 64) % 4 != 0) stall_left = idle_gap();
        if (stall_left > 0) begin
          stall_left--;
          byte_stall <= 1'b1;
        end else begin
          byte_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    int phase;
    int phase_start;
    int images;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = 1'b0;
    {red, green, blue} = '0;
    last_pixel = 1'b0;
    pixel_valid = 1'b0;
    items_sent = 0;
    hold_request = 0;
    prev_colour = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: single-pixel packets at the extremes, runs, mid-stream mode change
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'hffffff, 1'b1);
    send_pixel(24'haa55aa, 1'b0);
    send_pixel(24'haa55aa, 1'b1);
    send_pixel(24'h123456, 1'b0);
    send_pixel(24'h654321, 1'b0);
    send_pixel(24'h654321, 1'b1);
    send_pixel(24'h0f0f0f, 1'b0);
    send_pixel(24'h0f0f0f, 1'b0);
    send_pixel(24'h0f0f0f, 1'b0);
    // open run is flushed ahead of the raw word
    write_mode(MODE_RAW);
    send_pixel(24'h808080, 1'b0);
    send_pixel(24'hffffff, 1'b1);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'h5a5a5a, 1'b0);
    send_pixel(24'h5a5a5a, 1'b1);
    write_mode(MODE_RLE);
    send_pixel(24'hc7c7c7, 1'b0);
    send_pixel(24'h3c3c3c, 1'b1);
    send_pixel(24'h010203, 1'b0);
    send_pixel(24'h010203, 1'b1);

    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      if (phase == 0) begin
        // raw words fill the queue while the byte side holds off
        write_mode(MODE_RAW);
        hold_request = 1;
        phase_start = items_sent;
        while (items_sent < phase_start + 30) send_image(0, 0);
      end else begin
        if (phase == 1) write_mode(MODE_RLE);
        else write_mode($urandom_range(0, 1) ? MODE_RLE : MODE_RAW);
        images = $urandom_range(1, 3);
        for (int i = 0; i < images; i++)
          send_image(i == images - 1 && $urandom_range(0, 2) == 0,
                     (phase == 1 && i == 0) ? $urandom_range(MAX_RUN + 1, MAX_RUN + 3) : 0);
      end
      phase++;
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && bytes_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
